### rtl/core/pfs_pkg.sv
`default_nettype none

package pfs_pkg;

   // Field widths
   localparam int unsigned OVF_W    = 16;
   localparam int unsigned TS_W     = 32;
   localparam int unsigned PRE_W    = 11;
   localparam int unsigned RATIO_W  = 4;
   localparam int unsigned SHIFT_W  = 4;
   localparam int unsigned CMP_W    = 8;
   localparam int unsigned IDX_W    = 3;
   localparam int unsigned STAT_W   = 2;
   localparam int unsigned CSR_IX_W = 3;
   localparam int unsigned CSR_D_W  = 11;

   // prescale * period, then * denominator
   localparam int unsigned PROD1_W   = PRE_W + TS_W;
   localparam int unsigned PROD2_W   = PROD1_W + RATIO_W;
   localparam int unsigned DIV_STEPS = PROD2_W;
   localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

   // Register indexes
   localparam logic [CSR_IX_W-1:0] CSR_RATIO_NUM   = 3'd0;
   localparam logic [CSR_IX_W-1:0] CSR_RATIO_DEN   = 3'd1;
   localparam logic [CSR_IX_W-1:0] CSR_IN_PRESCALE = 3'd2;
   localparam logic [CSR_IX_W-1:0] CSR_SMOOTH_SH   = 3'd3;
   localparam logic [CSR_IX_W-1:0] CSR_CMP_MIN     = 3'd4;
   localparam logic [CSR_IX_W-1:0] CSR_CMP_MAX     = 3'd5;

   // Register reset values
   localparam logic [RATIO_W-1:0] RST_RATIO_NUM   = 4'd6;
   localparam logic [RATIO_W-1:0] RST_RATIO_DEN   = 4'd5;
   localparam logic [PRE_W-1:0]   RST_IN_PRESCALE = 11'd8;
   localparam logic [SHIFT_W-1:0] RST_SMOOTH_SH   = 4'd3;
   localparam logic [CMP_W-1:0]   RST_CMP_MIN     = 8'd10;
   localparam logic [CMP_W-1:0]   RST_CMP_MAX     = 8'd250;

   // Fit status codes
   localparam logic [STAT_W-1:0] STATUS_FIT      = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_MIN      = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_FALLBACK = 2'd2;

   localparam logic OP_OVERFLOW = 1'b0;
   localparam logic OP_CAPTURE  = 1'b1;

   typedef struct packed {
      logic [RATIO_W-1:0] ratio_numerator;
      logic [RATIO_W-1:0] ratio_denominator;
      logic [PRE_W-1:0]   input_prescale;
      logic [SHIFT_W-1:0] smoothing_shift;
      logic [CMP_W-1:0]   compare_min;
      logic [CMP_W-1:0]   compare_max;
   } cfg_type;

   typedef struct packed {
      logic             take;
      logic             avg_update;
      logic             mul1;
      logic             mul2;
      logic             div_step;
      logic             scan_step;
      logic [IDX_W-1:0] scan_idx;
      logic             scan_last;
      logic             load_out;
   } cmd_type;

   typedef struct packed {
      logic capture;
      logic dt_zero;
      logic avg_zero;
      logic fit;
   } sts_type;

   // Right shift taking the quotient for num down to 2*p*num:
   // p = 1,8,32,64,128,256,1024 -> 1 + log2(p)
   function automatic logic [SHIFT_W-1:0] scan_shift(input logic [IDX_W-1:0] idx);
      logic [SHIFT_W-1:0] sh;
      unique case (idx)
         3'd0:    sh = 4'd1;
         3'd1:    sh = 4'd4;
         3'd2:    sh = 4'd6;
         3'd3:    sh = 4'd7;
         3'd4:    sh = 4'd8;
         3'd5:    sh = 4'd9;
         default: sh = 4'd11;
      endcase
      return sh;
   endfunction

endpackage

`default_nettype wire

### rtl/core/pfs_cfg.sv
`default_nettype none

module pfs_cfg (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [pfs_pkg::CSR_IX_W-1:0]     csr_index,
   input  wire logic [pfs_pkg::CSR_D_W-1:0]      csr_wdata,
   output pfs_pkg::cfg_type                      cfg
);
   import pfs_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_RATIO_NUM:   cfg_in.ratio_numerator   = csr_wdata[RATIO_W-1:0];
            CSR_RATIO_DEN:   cfg_in.ratio_denominator = csr_wdata[RATIO_W-1:0];
            CSR_IN_PRESCALE: cfg_in.input_prescale    = csr_wdata[PRE_W-1:0];
            CSR_SMOOTH_SH:   cfg_in.smoothing_shift   = csr_wdata[SHIFT_W-1:0];
            CSR_CMP_MIN:     cfg_in.compare_min       = csr_wdata[CMP_W-1:0];
            CSR_CMP_MAX:     cfg_in.compare_max       = csr_wdata[CMP_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ratio_numerator   <= RST_RATIO_NUM;
         cfg_ff.ratio_denominator <= RST_RATIO_DEN;
         cfg_ff.input_prescale    <= RST_IN_PRESCALE;
         cfg_ff.smoothing_shift   <= RST_SMOOTH_SH;
         cfg_ff.compare_min       <= RST_CMP_MIN;
         cfg_ff.compare_max       <= RST_CMP_MAX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/pfs_dp.sv
`default_nettype none

module pfs_dp (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire pfs_pkg::cfg_type               cfg,
   input  wire pfs_pkg::cmd_type               cmd,
   output pfs_pkg::sts_type                    sts,
   input  wire logic                           req_opcode,
   input  wire logic [pfs_pkg::OVF_W-1:0]      req_capture_count,
   output logic [pfs_pkg::IDX_W-1:0]           rsp_prescaler_index,
   output logic [pfs_pkg::CMP_W-1:0]           rsp_compare_value,
   output logic [pfs_pkg::STAT_W-1:0]          rsp_fit_status,
   output logic [pfs_pkg::TS_W-1:0]            rsp_smoothed_period
);
   import pfs_pkg::*;

   // Architectural state
   logic [OVF_W-1:0]   ovf_ff, ovf_in;
   logic [TS_W-1:0]    last_ts_ff, last_ts_in;
   logic [TS_W-1:0]    avg_ff, avg_in;

   // Working registers
   logic [TS_W-1:0]    dt_ff, dt_in;
   logic [PROD1_W-1:0] prod1_ff, prod1_in;
   logic [PROD2_W-1:0] div_ff, div_in;      // dividend in, quotient out
   logic [RATIO_W-1:0] rem_ff, rem_in;
   logic               low0_ff, low0_in;
   logic [IDX_W-1:0]   cand_idx_ff, cand_idx_in;
   logic [CMP_W-1:0]   cand_cmp_ff, cand_cmp_in;
   logic [STAT_W-1:0]  cand_stat_ff, cand_stat_in;
   logic [IDX_W-1:0]   out_idx_ff;
   logic [CMP_W-1:0]   out_cmp_ff;
   logic [STAT_W-1:0]  out_stat_ff;
   logic [TS_W-1:0]    out_avg_ff;

   logic [TS_W-1:0]    now_ts;
   logic [TS_W-1:0]    diff;
   logic [TS_W-1:0]    diff_sh;
   logic [RATIO_W:0]   rem_trial;
   logic               rem_ge;
   logic [PROD2_W-1:0] q_s;
   logic [PROD2_W-1:0] v_s;
   logic               v_narrow;
   logic               v_fit;
   logic               v_low;
   logic               low_sel;

   assign now_ts  = {ovf_ff, req_capture_count};
   assign diff    = dt_ff - avg_ff;
   assign diff_sh = TS_W'($signed(diff) >>> cfg.smoothing_shift);

   // Restoring divide step: one quotient bit per cycle
   assign rem_trial = {rem_ff, div_ff[PROD2_W-1]};
   assign rem_ge    = rem_trial >= {1'b0, cfg.ratio_numerator};

   // Candidate compare value for the prescaler under scan
   assign q_s      = div_ff >> scan_shift(cmd.scan_idx);
   assign v_s      = (q_s == '0) ? '0 : q_s - PROD2_W'(1);
   assign v_narrow = (v_s[PROD2_W-1:CMP_W] == '0);
   assign v_fit    = v_narrow && (v_s[CMP_W-1:0] >= cfg.compare_min)
                              && (v_s[CMP_W-1:0] <= cfg.compare_max);
   assign v_low    = (q_s == '0) || (v_narrow && (v_s[CMP_W-1:0] < cfg.compare_min));
   assign low_sel  = (cmd.scan_idx == '0) ? v_low : low0_ff;

   assign sts.capture  = (req_opcode == OP_CAPTURE);
   assign sts.dt_zero  = (dt_ff == '0);
   assign sts.avg_zero = (avg_ff == '0);
   assign sts.fit      = v_fit;

   always_comb begin
      ovf_in       = ovf_ff;
      last_ts_in   = last_ts_ff;
      avg_in       = avg_ff;
      dt_in        = dt_ff;
      prod1_in     = prod1_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      low0_in      = low0_ff;
      cand_idx_in  = cand_idx_ff;
      cand_cmp_in  = cand_cmp_ff;
      cand_stat_in = cand_stat_ff;

      if (cmd.take) begin
         if (req_opcode == OP_OVERFLOW) begin
            ovf_in = ovf_ff + OVF_W'(1);
         end else begin
            dt_in      = now_ts - last_ts_ff;
            last_ts_in = now_ts;
         end
      end

      if (cmd.avg_update) begin
         avg_in = (avg_ff == '0) ? dt_ff : avg_ff + diff_sh;
      end

      if (cmd.mul1) begin
         prod1_in = PROD1_W'(cfg.input_prescale) * PROD1_W'(avg_ff);
      end

      if (cmd.mul2) begin
         div_in = PROD2_W'(prod1_ff) * PROD2_W'(cfg.ratio_denominator);
         rem_in = '0;
      end

      // A zero numerator sets every quotient bit: saturated quotient
      if (cmd.div_step) begin
         div_in = {div_ff[PROD2_W-2:0], rem_ge};
         rem_in = rem_ge ? RATIO_W'(rem_trial - {1'b0, cfg.ratio_numerator})
                         : rem_trial[RATIO_W-1:0];
      end

      if (cmd.scan_step) begin
         if (cmd.scan_idx == '0) begin
            low0_in = v_low;
         end
         if (v_fit) begin
            cand_idx_in  = cmd.scan_idx;
            cand_cmp_in  = v_s[CMP_W-1:0];
            cand_stat_in = STATUS_FIT;
         end else if (cmd.scan_last) begin
            if (low_sel) begin
               cand_idx_in  = '0;
               cand_cmp_in  = cfg.compare_min;
               cand_stat_in = STATUS_MIN;
            end else begin
               cand_idx_in  = cmd.scan_idx;
               cand_cmp_in  = (v_narrow && (v_s[CMP_W-1:0] <= cfg.compare_max))
                              ? v_s[CMP_W-1:0] : cfg.compare_max;
               cand_stat_in = STATUS_FALLBACK;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovf_ff     <= '0;
         last_ts_ff <= '0;
         avg_ff     <= '0;
      end else begin
         ovf_ff     <= ovf_in;
         last_ts_ff <= last_ts_in;
         avg_ff     <= avg_in;
      end
   end

   always_ff @(posedge clock) begin
      dt_ff        <= dt_in;
      prod1_ff     <= prod1_in;
      div_ff       <= div_in;
      rem_ff       <= rem_in;
      low0_ff      <= low0_in;
      cand_idx_ff  <= cand_idx_in;
      cand_cmp_ff  <= cand_cmp_in;
      cand_stat_ff <= cand_stat_in;
      if (cmd.load_out) begin
         out_idx_ff  <= cand_idx_ff;
         out_cmp_ff  <= cand_cmp_ff;
         out_stat_ff <= cand_stat_ff;
         out_avg_ff  <= avg_ff;
      end
   end

   assign rsp_prescaler_index = out_idx_ff;
   assign rsp_compare_value   = out_cmp_ff;
   assign rsp_fit_status      = out_stat_ff;
   assign rsp_smoothed_period = out_avg_ff;

endmodule

`default_nettype wire

### rtl/core/pfs_ctrl.sv
`default_nettype none

module pfs_ctrl #(
   parameter int unsigned PRESCALER_COUNT = 7
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   input  wire pfs_pkg::sts_type sts,
   output pfs_pkg::cmd_type cmd
);
   import pfs_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_AVG  = 3'd1;
   localparam logic [2:0] ST_MUL1 = 3'd2;
   localparam logic [2:0] ST_MUL2 = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_SCAN = 3'd5;
   localparam logic [2:0] ST_LOAD = 3'd6;

   localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_STEPS - 1);
   localparam logic [IDX_W-1:0] SCAN_LAST = IDX_W'(PRESCALER_COUNT - 1);

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      cmd           = '0;
      cmd.scan_idx  = cnt_ff[IDX_W-1:0];
      cmd.scan_last = (cnt_ff[IDX_W-1:0] == SCAN_LAST);

      unique case (state_ff)
         ST_IDLE: begin
            cmd.take = req_valid;
            if (req_valid && sts.capture) begin
               state_in = ST_AVG;
            end
         end
         ST_AVG: begin
            cmd.avg_update = !sts.dt_zero;
            state_in       = sts.dt_zero ? ST_IDLE : ST_MUL1;
         end
         ST_MUL1: begin
            cmd.mul1 = !sts.avg_zero;
            state_in = sts.avg_zero ? ST_IDLE : ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == DIV_LAST) begin
               cnt_in   = '0;
               state_in = ST_SCAN;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.fit || cmd.scan_last) begin
               state_in = ST_LOAD;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_LOAD: begin
            cmd.load_out = out_free;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = cmd.load_out || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_LOAD)
      else $error("result raised outside load");

   a_load_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD && out_free) |=> (state_ff == ST_IDLE && rsp_valid_ff))
      else $error("load did not deliver result");

   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> cnt_ff < CNT_W'(PRESCALER_COUNT))
      else $error("scan index out of range");

   a_div_to_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && cnt_ff == DIV_LAST) |=> (state_ff == ST_SCAN && cnt_ff == '0))
      else $error("divide did not hand over to scan");
`endif

endmodule

`default_nettype wire

### rtl/core/period_to_compare_frequency_scaler.sv
// Channel | Direction | Handshake              | Payload
// req     | in        | req_valid / req_stall  | opcode, capture_count
// rsp     | out       | rsp_valid / rsp_stall  | prescaler_index, compare_value,
//         |           |                        | fit_status, smoothed_period
// csr     | in        | csr_valid / csr_ready  | index, wdata (ready always high)
//
// Overflow transaction: no result.
// Capture transaction: ends in the average state when the period is zero, in the
//   first multiply state when the new average is zero; else take, average, two multiply
//   stages, a restoring divide of the 47-bit product (one quotient bit per cycle),
//   a scan of up to PRESCALER_COUNT prescalers, one load.
// Synchronous active-high reset; no clearing pass.
// A finished result sits in the output register while the next transaction
//   is taken; a new result waits in the load state while rsp_stall holds it.
`default_nettype none

module period_to_compare_frequency_scaler #(
   parameter int unsigned PRESCALER_COUNT = 7
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request channel
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic                             req_opcode,
   input  wire logic [pfs_pkg::OVF_W-1:0]        req_capture_count,
   // result channel
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [pfs_pkg::IDX_W-1:0]             rsp_prescaler_index,
   output logic [pfs_pkg::CMP_W-1:0]             rsp_compare_value,
   output logic [pfs_pkg::STAT_W-1:0]            rsp_fit_status,
   output logic [pfs_pkg::TS_W-1:0]              rsp_smoothed_period,
   // register write channel
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [pfs_pkg::CSR_IX_W-1:0]     csr_index,
   input  wire logic [pfs_pkg::CSR_D_W-1:0]      csr_wdata
);
   import pfs_pkg::*;

   cfg_type cfg;   // live register values
   cmd_type cmd;   // controller -> datapath
   sts_type sts;   // datapath -> controller

   pfs_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Sequencer: one transaction in flight, scan bounded by PRESCALER_COUNT
   pfs_ctrl #(
      .PRESCALER_COUNT (PRESCALER_COUNT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Timestamp, average, multiply, divide, scan and output register.
   // The quotient is taken once against num; each prescaler is a shift of it.
   pfs_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_opcode          (req_opcode),
      .req_capture_count   (req_capture_count),
      .rsp_prescaler_index (rsp_prescaler_index),
      .rsp_compare_value   (rsp_compare_value),
      .rsp_fit_status      (rsp_fit_status),
      .rsp_smoothed_period (rsp_smoothed_period)
   );

endmodule

`default_nettype wire

### sim/testbench.sv
module testbench;
   import pfs_pkg::*;

   localparam int unsigned SCAN_COUNT   = 7;
   localparam int unsigned DRAIN_CYCLES = 100;      // well beyond one capture transaction
   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int unsigned HOLD_PERIOD  = 16384;    // receiver hold-off repeats this often
   localparam int unsigned HOLD_START   = 8000;
   localparam int unsigned HOLD_LENGTH  = 700;

   // One request transaction: overflow or capture event
   typedef struct packed {
      logic             op;
      logic [OVF_W-1:0] count;
   } event_type;

   // One result transaction: the chosen output timer setting
   typedef struct packed {
      logic [IDX_W-1:0]  prescaler;
      logic [CMP_W-1:0]  compare;
      logic [STAT_W-1:0] status;
      logic [TS_W-1:0]   period;
   } setting_type;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_type;

   logic                clock             = 1'b0;
   logic                reset             = 1'b1;
   logic                req_valid         = 1'b0;
   logic                req_stall;
   logic                req_opcode        = OP_OVERFLOW;
   logic [OVF_W-1:0]    req_capture_count = '0;
   logic                rsp_valid;
   logic                rsp_stall         = 1'b0;
   logic [IDX_W-1:0]    rsp_prescaler_index;
   logic [CMP_W-1:0]    rsp_compare_value;
   logic [STAT_W-1:0]   rsp_fit_status;
   logic [TS_W-1:0]     rsp_smoothed_period;
   logic                csr_valid         = 1'b0;
   logic                csr_ready;
   logic [CSR_IX_W-1:0] csr_index         = CSR_RATIO_NUM;
   logic [CSR_D_W-1:0]  csr_wdata         = '0;

   // Register copy and tracked state, both mirroring the block
   cfg_type          live_cfg = '{RST_RATIO_NUM, RST_RATIO_DEN, RST_IN_PRESCALE,
                                  RST_SMOOTH_SH, RST_CMP_MIN, RST_CMP_MAX};
   logic [OVF_W-1:0] seen_overflows = '0;
   logic [TS_W-1:0]  last_stamp     = '0;
   logic [TS_W-1:0]  mean_period    = '0;

   setting_type      expected_settings[$];
   event_type        pending_events[$];
   int unsigned      queued_count   = 0;
   int unsigned      accepted_count = 0;
   int unsigned      error_count    = 0;

   // Stimulus-side view of the timestamps, so trains can be laid out by period
   logic [OVF_W-1:0] plan_ovf   = '0;
   logic [TS_W-1:0]  plan_stamp = '0;

   // Driver bookkeeping
   int unsigned      burst_left = 1;
   int unsigned      gap_left   = 0;
   logic             offering;
   event_type        next_event;

   // Receiver bookkeeping
   int unsigned      stall_cycles = 0;
   stall_style_type  stall_style  = STALL_NONE;
   int unsigned      sim_cycles   = 0;

   period_to_compare_frequency_scaler #(
      .PRESCALER_COUNT(SCAN_COUNT)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_capture_count  (req_capture_count),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_prescaler_index(rsp_prescaler_index),
      .rsp_compare_value  (rsp_compare_value),
      .rsp_fit_status     (rsp_fit_status),
      .rsp_smoothed_period(rsp_smoothed_period),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Exact quotient prescale*period*den / (2*p*num); a zero divisor saturates
   function automatic logic [63:0] scaled_quotient(int unsigned slot, logic [TS_W-1:0] period);
      logic [63:0] dividend;
      logic [63:0] divisor;
      dividend = 64'(live_cfg.input_prescale) * 64'(period) * 64'(live_cfg.ratio_denominator);
      case (slot)
         0:       divisor = 64'd1;
         1:       divisor = 64'd8;
         2:       divisor = 64'd32;
         3:       divisor = 64'd64;
         4:       divisor = 64'd128;
         5:       divisor = 64'd256;
         default: divisor = 64'd1024;
      endcase
      divisor = 64'd2 * divisor * 64'(live_cfg.ratio_numerator);
      if (divisor == 64'd0) return '1;
      return dividend / divisor;
   endfunction

   // Advances the tracked state by one accepted transaction and queues the
   // setting that it produces, if any
   function automatic void compute_compare_setting(logic op, logic [OVF_W-1:0] count);
      logic [TS_W-1:0] stamp;
      logic [TS_W-1:0] period;
      logic [TS_W-1:0] diff;
      logic [TS_W-1:0] step;
      logic [63:0]     q;
      logic [63:0]     v;
      setting_type     result;
      logic            hit;
      int unsigned     slot;
      if (op == OP_OVERFLOW) begin
         seen_overflows = seen_overflows + 1'b1;
         return;
      end
      stamp = {seen_overflows, count};
      period = stamp - last_stamp;
      last_stamp = stamp;
      if (period == '0) return;
      if (mean_period == '0) begin
         mean_period = period;
      end else begin
         diff = period - mean_period;
         step = $signed(diff) >>> live_cfg.smoothing_shift;
         mean_period = mean_period + step;
      end
      if (mean_period == '0) return;

      result = '0;
      result.period = mean_period;
      hit = 1'b0;
      for (slot = 0; slot < SCAN_COUNT; slot++) begin
         if (!hit) begin
            q = scaled_quotient(slot, mean_period);
            v = (q > 0) ? q - 1 : 64'd0;
            if (v >= live_cfg.compare_min && v <= live_cfg.compare_max) begin
               hit = 1'b1;
               result.prescaler = IDX_W'(slot);
               result.compare = v[CMP_W-1:0];
               result.status = STATUS_FIT;
            end
         end
      end
      if (!hit) begin
         q = scaled_quotient(0, mean_period);
         if (q == 0 || q - 1 < live_cfg.compare_min) begin
            // too fast even for prescaler 1: clamp to min
            result.prescaler = '0;
            result.compare = live_cfg.compare_min;
            result.status = STATUS_MIN;
         end else begin
            // too slow: largest prescaler, clamped to max
            q = scaled_quotient(SCAN_COUNT - 1, mean_period);
            v = (q > 0) ? q - 1 : 64'd0;
            result.prescaler = IDX_W'(SCAN_COUNT - 1);
            result.compare = (v > live_cfg.compare_max) ? live_cfg.compare_max : v[CMP_W-1:0];
            result.status = STATUS_FALLBACK;
         end
      end
      expected_settings.push_back(result);
   endfunction

   function automatic void queue_item(logic op, logic [OVF_W-1:0] count);
      event_type item;
      item.op = op;
      item.count = count;
      pending_events.push_back(item);
      queued_count++;
      if (op == OP_OVERFLOW) plan_ovf = plan_ovf + 1'b1;
      else plan_stamp = {plan_ovf, count};
   endfunction

   // Overflow events up to the upper half of the stamp, then the capture
   function automatic void queue_capture_at(logic [TS_W-1:0] stamp);
      while (plan_ovf != stamp[TS_W-1:OVF_W]) queue_item(OP_OVERFLOW, OVF_W'($urandom));
      queue_item(OP_CAPTURE, stamp[OVF_W-1:0]);
   endfunction

   // Mostly trains of captures at a steady, jittered period spread over
   // decades, with random noise and repeated stamps mixed in
   function automatic void queue_random_events(int unsigned amount);
      int unsigned     target;
      int unsigned     kind;
      int unsigned     span;
      logic [TS_W-1:0] spacing;
      logic [TS_W-1:0] base;
      target = queued_count + amount;
      while (queued_count < target) begin
         kind = $urandom_range(0, 9);
         if (kind < 7) begin
            span = $urandom_range(0, 19);
            spacing = (32'd1 << span) | ($urandom & ((32'd1 << span) - 1));
            repeat ($urandom_range(3, 12)) begin
               base = (plan_stamp[TS_W-1:OVF_W] == plan_ovf) ? plan_stamp : {plan_ovf, 16'h0};
               queue_capture_at(base + spacing - (spacing >> 4)
                                + ($urandom % ((spacing >> 3) + 1)));
            end
         end else if (kind < 9) begin
            repeat ($urandom_range(1, 6))
               queue_item($urandom_range(0, 1) ? OP_CAPTURE : OP_OVERFLOW, OVF_W'($urandom));
         end else if (plan_stamp[TS_W-1:OVF_W] == plan_ovf) begin
            queue_item(OP_CAPTURE, plan_stamp[OVF_W-1:0]);   // zero period
         end
      end
   endfunction

   // Holds csr_valid high; the caller lowers it after the last write
   task automatic write_register(input logic [CSR_IX_W-1:0] ix, input logic [CSR_D_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= ix;
      csr_wdata <= value;
      do @(posedge clock);
      while (csr_ready !== 1'b1);
      case (ix)
         CSR_RATIO_NUM:   live_cfg.ratio_numerator = value[RATIO_W-1:0];
         CSR_RATIO_DEN:   live_cfg.ratio_denominator = value[RATIO_W-1:0];
         CSR_IN_PRESCALE: live_cfg.input_prescale = value[PRE_W-1:0];
         CSR_SMOOTH_SH:   live_cfg.smoothing_shift = value[SHIFT_W-1:0];
         CSR_CMP_MIN:     live_cfg.compare_min = value[CMP_W-1:0];
         CSR_CMP_MAX:     live_cfg.compare_max = value[CMP_W-1:0];
         default: ;
      endcase
   endtask

   task automatic program_settings(input logic [RATIO_W-1:0] num, input logic [RATIO_W-1:0] den,
                                   input logic [PRE_W-1:0] pre, input logic [SHIFT_W-1:0] sh,
                                   input logic [CMP_W-1:0] lo, input logic [CMP_W-1:0] hi);
      write_register(CSR_RATIO_NUM, CSR_D_W'(num));
      write_register(CSR_RATIO_DEN, CSR_D_W'(den));
      write_register(CSR_IN_PRESCALE, CSR_D_W'(pre));
      write_register(CSR_SMOOTH_SH, CSR_D_W'(sh));
      write_register(CSR_CMP_MIN, CSR_D_W'(lo));
      write_register(CSR_CMP_MAX, CSR_D_W'(hi));
      csr_valid <= 1'b0;
   endtask

   // Every transaction taken, every result back, then room for a trailing
   // capture that yields nothing
   task automatic wait_until_drained();
      do @(posedge clock);
      while (accepted_count != queued_count || expected_settings.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Request driver: bursts of random length, gaps of random length between.
   // The payload holds still while req_stall is up.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         offering = req_valid;
         if (req_valid && !req_stall) begin
            compute_compare_setting(req_opcode, req_capture_count);
            accepted_count++;
            offering = 1'b0;
         end
         if (!offering) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_events.size() != 0) begin
               next_event = pending_events.pop_front();
               req_valid <= 1'b1;
               req_opcode <= next_event.op;
               req_capture_count <= next_event.count;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  case ($urandom_range(0, 3))
                     0:       gap_left = 0;
                     1:       gap_left = $urandom_range(1, 4);
                     2:       gap_left = $urandom_range(5, 30);
                     default: gap_left = $urandom_range(31, 80);
                  endcase
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result stall: a style picked at random, plus a long hold-off once
   // per period so the block backs up and stalls its request side
   always @(posedge clock) begin
      stall_cycles++;
      if (stall_cycles % 512 == 0) stall_style = stall_style_type'($urandom_range(0, 3));
      if (stall_cycles % HOLD_PERIOD >= HOLD_START &&
          stall_cycles % HOLD_PERIOD < HOLD_START + HOLD_LENGTH) begin
         rsp_stall <= 1'b1;
      end else begin
         case (stall_style)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     rsp_stall <= ((stall_cycles % 7) < 3);
         endcase
      end
   end

   function automatic void check_field(string label, logic [TS_W-1:0] want, logic [TS_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, label, want, got);
         error_count++;
      end
   endfunction

   // Result monitor: each accepted transaction against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_settings.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual %0d/%0d/%0d/%0d", $time,
                     rsp_prescaler_index, rsp_compare_value, rsp_fit_status,
                     rsp_smoothed_period);
            error_count++;
         end else begin
            check_field("prescaler_index", expected_settings[0].prescaler, rsp_prescaler_index);
            check_field("compare_value", expected_settings[0].compare, rsp_compare_value);
            check_field("fit_status", expected_settings[0].status, rsp_fit_status);
            check_field("smoothed_period", expected_settings[0].period, rsp_smoothed_period);
            void'(expected_settings.pop_front());
         end
      end
   end

   // Watchdog
   initial begin
      while (sim_cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         sim_cycles++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin
      logic [CMP_W-1:0] lo;
      logic [CMP_W-1:0] hi;
      logic [CMP_W-1:0] swap;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset settings. Zero period straight after reset, a one-tick period
      // (clamped to min), a step back by one tick that drives the average to
      // zero, a repeated stamp, a fresh load, then rising and falling steps.
      queue_item(OP_CAPTURE, 16'h0000);
      queue_item(OP_CAPTURE, 16'h0001);
      queue_item(OP_CAPTURE, 16'h0000);
      queue_item(OP_CAPTURE, 16'h0000);
      queue_item(OP_CAPTURE, 16'd30);
      queue_item(OP_CAPTURE, 16'hFFFF);
      queue_item(OP_OVERFLOW, 16'hFFFF);
      queue_item(OP_CAPTURE, 16'h0000);
      queue_item(OP_OVERFLOW, 16'h0000);
      queue_random_events(240);
      wait_until_drained();

      // Extremes: widest window, no smoothing. Quotient of zero, then the
      // largest wrapped period forcing the fallback.
      program_settings(4'd15, 4'd1, 11'd1, 4'd0, 8'd0, 8'd255);
      queue_item(OP_OVERFLOW, 16'h5A5A);
      queue_item(OP_CAPTURE, 16'h0100);
      queue_item(OP_CAPTURE, 16'h0101);
      queue_item(OP_CAPTURE, 16'h0100);
      queue_item(OP_CAPTURE, 16'h0102);
      queue_item(OP_CAPTURE, 16'h8000);
      queue_random_events(240);
      wait_until_drained();

      // Opposite extremes: min above max, heaviest smoothing
      program_settings(4'd1, 4'd15, 11'd1024, 4'd15, 8'd255, 8'd0);
      queue_random_events(150);
      wait_until_drained();

      // Zero numerator: divisor of zero saturates the quotient
      program_settings(4'd0, 4'd5, 11'd8, 4'd3, 8'd10, 8'd250);
      queue_random_events(40);
      wait_until_drained();

      // Random settings, window mostly ordered
      repeat (5) begin
         lo = CMP_W'($urandom);
         hi = CMP_W'($urandom);
         if (lo > hi && $urandom_range(0, 4) != 0) begin
            swap = lo;
            lo = hi;
            hi = swap;
         end
         program_settings(RATIO_W'($urandom_range(1, 15)), RATIO_W'($urandom_range(1, 15)),
                          PRE_W'($urandom_range(1, 1024)), SHIFT_W'($urandom_range(0, 15)),
                          lo, hi);
         queue_random_events(230);
         wait_until_drained();
      end

      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

### sim.f
rtl/core/pfs_pkg.sv
rtl/core/pfs_cfg.sv
rtl/core/pfs_dp.sv
rtl/core/pfs_ctrl.sv
rtl/core/period_to_compare_frequency_scaler.sv
sim/testbench.sv
